[hw/rtl/rckp_pkg.sv]
// Shared types, constants and the nucleotide code table of the k-mer packer.
package rckp_pkg;

    // Default upper bound on the k-mer length; the top level takes it as a parameter.
    localparam int MAX_KMER_LEN = 32;

    // Field widths.
    localparam int BASE_W     = 8;
    localparam int BIN_W      = 8;
    localparam int WORD_W     = 64;
    localparam int KLEN_W     = 6;
    localparam int NUC_W      = 2;
    localparam int BIN_NUCS   = 4;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 72;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [KLEN_W-1:0] KLEN_RESET  = 6'd27;
    localparam logic              CANON_RESET = 1'b1;
    localparam logic [KLEN_W-1:0] FILL_MAX    = 6'd63;

    // Complementing a 2-bit code flips both bits.
    localparam logic [NUC_W-1:0] NUC_COMP = 2'b11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KMER_LEN = 1'b0,
        CFG_CANON    = 1'b1
    } t_cfg_idx;

    // Per-cell control: load on an accepted item, zero forces the loaded value to zero.
    typedef struct packed {
        logic load;
        logic zero;
    } t_cell_ctrl;

    // ASCII character to 2-bit nucleotide code, indexed by bits 2:1.
    function automatic logic [NUC_W-1:0] base_code(input logic [BASE_W-1:0] ch);
        logic [NUC_W-1:0] code;
        case (ch[2:1])
            2'd0:    code = 2'd0;
            2'd1:    code = 2'd1;
            2'd2:    code = 2'd3;
            2'd3:    code = 2'd2;
            default: code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/rckp_cell.sv]
// One nucleotide cell of the shifting window.
module rckp_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rckp_pkg::t_cell_ctrl               i_ctrl,
    input  logic [rckp_pkg::NUC_W-1:0]         i_nuc,
    output logic [rckp_pkg::NUC_W-1:0]         o_nuc
);

    logic [rckp_pkg::NUC_W-1:0] r_nuc;
    logic [rckp_pkg::NUC_W-1:0] n_nuc;

    assign n_nuc = i_ctrl.zero ? '0 : i_nuc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nuc <= '0;
        end else if (i_ctrl.load) begin
            r_nuc <= n_nuc;
        end
    end

    assign o_nuc = r_nuc;

endmodule

[hw/rtl/rckp_canon.sv]
// Reverse-complement compare, forward/canonical select and output register.
module rckp_canon #(
    parameter int MAX_KMER_LEN = rckp_pkg::MAX_KMER_LEN
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [MAX_KMER_LEN-1:0][rckp_pkg::NUC_W-1:0]  i_word,
    input  logic [rckp_pkg::BIN_NUCS-1:0][rckp_pkg::NUC_W-1:0] i_bin,
    input  logic [rckp_pkg::KLEN_W-1:0]                   i_k,
    input  logic                                          i_canon,
    input  logic                                          i_load,
    input  logic                                          i_tready,
    output logic                                          o_can_take,
    output logic                                          o_valid,
    output logic [rckp_pkg::BIN_W-1:0]                    o_bin,
    output logic [rckp_pkg::WORD_W-1:0]                   o_word
);

    localparam int N_NUCS = MAX_KMER_LEN + rckp_pkg::BIN_NUCS;
    localparam int NIDX_W = $clog2(N_NUCS);
    localparam int KW     = rckp_pkg::KLEN_W;
    localparam int NW     = rckp_pkg::NUC_W;

    logic [KW-1:0]             w_n;
    logic [N_NUCS-1:0][NW-1:0] w_pos;   // position 0 is the newest nucleotide
    logic [N_NUCS-1:0][NW-1:0] w_seq;   // index 0 is the oldest nucleotide
    logic [N_NUCS-1:0][NW-1:0] w_fwd_cmp;
    logic [N_NUCS-1:0][NW-1:0] w_rc_cmp;
    logic [rckp_pkg::BIN_NUCS-1:0][NW-1:0] w_rb;
    logic [MAX_KMER_LEN-1:0][NW-1:0]       w_rw;
    logic                      w_rc_less;
    logic                      w_use_rc;

    logic                            r_valid;
    logic [rckp_pkg::BIN_W-1:0]      r_bin;
    logic [rckp_pkg::WORD_W-1:0]     r_word;

    assign w_n = i_k + KW'(rckp_pkg::BIN_NUCS);

    genvar p;
    generate
        for (p = 0; p < N_NUCS; p++) begin : g_pos
            logic [KW-1:0] w_off;
            logic [KW-1:0] w_ridx;
            assign w_off  = KW'(p) - i_k;
            assign w_ridx = w_n - KW'(1) - KW'(p);
            if (p < MAX_KMER_LEN) begin : g_lo
                always_comb begin
                    w_pos[p] = '0;
                    if (KW'(p) < i_k) begin
                        w_pos[p] = i_word[p];
                    end else if (w_off < KW'(rckp_pkg::BIN_NUCS)) begin
                        w_pos[p] = i_bin[w_off[1:0]];
                    end
                end
            end else begin : g_hi
                always_comb begin
                    w_pos[p] = '0;
                    if (w_off < KW'(rckp_pkg::BIN_NUCS)) begin
                        w_pos[p] = i_bin[w_off[1:0]];
                    end
                end
            end
            // Reverse the window: sequence index p reads position n-1-p.
            always_comb begin
                w_seq[p] = '0;
                if (KW'(p) < w_n) begin
                    w_seq[p] = w_pos[w_ridx[NIDX_W-1:0]];
                end
            end
            // Oldest-first digits, oldest in the top bits.
            assign w_fwd_cmp[N_NUCS-1-p] = w_seq[p];
            assign w_rc_cmp[N_NUCS-1-p]  = (KW'(p) < w_n) ? (w_pos[p] ^ rckp_pkg::NUC_COMP) : '0;
        end

        for (p = 0; p < rckp_pkg::BIN_NUCS; p++) begin : g_rb
            assign w_rb[rckp_pkg::BIN_NUCS-1-p] = w_pos[p] ^ rckp_pkg::NUC_COMP;
        end

        for (p = 0; p < MAX_KMER_LEN; p++) begin : g_rw
            assign w_rw[p] = (KW'(p) < i_k) ? (w_seq[p] ^ rckp_pkg::NUC_COMP) : '0;
        end
    endgenerate

    assign w_rc_less = w_rc_cmp < w_fwd_cmp;
    assign w_use_rc  = i_canon && w_rc_less;

    assign o_can_take = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin  <= w_use_rc ? w_rb : i_bin;
            r_word <= w_use_rc ? rckp_pkg::WORD_W'(w_rw) : rckp_pkg::WORD_W'(i_word);
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_word  = r_word;

endmodule

[hw/rtl/rolling_canonical_kmer_packer_top.sv]
// Top level of the rolling canonical k-mer packer: config, cell row, handshake.
//
// Takes one ASCII nucleotide per item, codes it to two bits (A=0, C=1, G=2, T=3, from
// bits 2:1 of the character) and shifts it into a row of MAX_KMER_LEN+4 cells. The newest
// k cells form the k-mer word, the four behind them the bin. Once k+4 nucleotides have
// been seen since the last new_sequence flag, every item yields one (bin, word) result;
// in canonical mode the result is the lexicographically smaller of the window and its
// reverse complement, the forward window on a tie. Throughput is one item per clock while
// the output is not stalled: an item is first registered in the cell row, and the
// reverse-complement compare sits in front of the output register, which takes the
// result once it is free. Items that yield no result leave nothing behind. One result
// may wait in the output register while the next item is held in the cell row; input
// ready drops only when both are occupied. kmer_length of zero acts as one, above
// MAX_KMER_LEN as MAX_KMER_LEN. Write config only while no item is in flight.
module rolling_canonical_kmer_packer_top #(
    parameter int MAX_KMER_LEN = rckp_pkg::MAX_KMER_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [rckp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rckp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rckp_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [7:0] base_char
    input  logic                                s_axis_tuser,  // [0] new_sequence
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rckp_pkg::M_TDATA_W-1:0]      m_axis_tdata   // [7:0] bin_prefix,
                                                               // [71:8] kmer_word
);

    localparam int KW     = rckp_pkg::KLEN_W;
    localparam int NW     = rckp_pkg::NUC_W;
    localparam int NBIN   = rckp_pkg::BIN_NUCS;
    localparam int KIDX_W = $clog2(MAX_KMER_LEN);

    logic [KW-1:0] r_kmer_len;
    logic          r_canon;
    logic [KW-1:0] r_fill;
    logic [KW-1:0] n_fill;
    logic          r_pend;
    logic          n_pend;

    logic [KW-1:0] w_k;
    logic [KW-1:0] w_k_m1;
    logic [KW-1:0] w_fill_base;
    logic          w_accept;
    logic          w_emit;
    logic          w_can_take;
    logic          w_load;
    logic [NW-1:0] w_code;
    logic [NW-1:0] w_bin_feed;

    logic [MAX_KMER_LEN-1:0][NW-1:0] w_word;
    logic [NBIN-1:0][NW-1:0]         w_bin;

    logic [rckp_pkg::BIN_W-1:0]      w_out_bin;
    logic [rckp_pkg::WORD_W-1:0]     w_out_word;

    // Clamp the configured length into 1..MAX_KMER_LEN.
    always_comb begin
        w_k = r_kmer_len;
        if (r_kmer_len == '0) begin
            w_k = KW'(1);
        end else if (r_kmer_len > KW'(MAX_KMER_LEN)) begin
            w_k = KW'(MAX_KMER_LEN);
        end
    end
    assign w_k_m1 = w_k - KW'(1);

    // Config registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= rckp_pkg::KLEN_RESET;
            r_canon    <= rckp_pkg::CANON_RESET;
        end else if (i_cfg_we) begin
            case (rckp_pkg::t_cfg_idx'(i_cfg_idx))
                rckp_pkg::CFG_KMER_LEN: r_kmer_len <= i_cfg_data[KW-1:0];
                rckp_pkg::CFG_CANON:    r_canon    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the cell row doubles as the stage that holds a window awaiting output.
    assign s_axis_tready = !r_pend || w_can_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = r_pend && w_can_take;

    assign w_code      = rckp_pkg::base_code(s_axis_tdata[rckp_pkg::BASE_W-1:0]);
    assign w_fill_base = s_axis_tuser ? '0 : r_fill;
    assign n_fill      = (w_fill_base == rckp_pkg::FILL_MAX) ? w_fill_base
                                                              : w_fill_base + KW'(1);
    assign w_emit      = n_fill >= (w_k + KW'(NBIN));

    always_comb begin
        n_pend = r_pend;
        if (w_accept) begin
            n_pend = w_emit;
        end else if (w_load) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_accept) begin
                r_fill <= n_fill;
            end
        end
    end

    // The oldest word nucleotide drops into the bin; a new sequence drops zero.
    assign w_bin_feed = w_word[w_k_m1[KIDX_W-1:0]];

    genvar j;
    generate
        for (j = 0; j < MAX_KMER_LEN; j++) begin : g_word
            rckp_pkg::t_cell_ctrl w_ctrl;
            logic [NW-1:0]        w_in;
            assign w_ctrl.load = w_accept;
            if (j == 0) begin : g_head
                assign w_ctrl.zero = 1'b0;
                assign w_in        = w_code;
            end else begin : g_body
                // Clear on a new sequence, mask cells beyond the current length.
                assign w_ctrl.zero = s_axis_tuser || (KW'(j) >= w_k);
                assign w_in        = w_word[j-1];
            end
            rckp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_nuc   (w_in),
                .o_nuc   (w_word[j])
            );
        end

        for (j = 0; j < NBIN; j++) begin : g_bin
            rckp_pkg::t_cell_ctrl w_ctrl;
            logic [NW-1:0]        w_in;
            assign w_ctrl.load = w_accept;
            assign w_ctrl.zero = s_axis_tuser;
            if (j == 0) begin : g_head
                assign w_in = w_bin_feed;
            end else begin : g_body
                assign w_in = w_bin[j-1];
            end
            rckp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_nuc   (w_in),
                .o_nuc   (w_bin[j])
            );
        end
    endgenerate

    rckp_canon #(
        .MAX_KMER_LEN (MAX_KMER_LEN)
    ) u_canon (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (w_word),
        .i_bin      (w_bin),
        .i_k        (w_k),
        .i_canon    (r_canon),
        .i_load     (w_load),
        .i_tready   (m_axis_tready),
        .o_can_take (w_can_take),
        .o_valid    (m_axis_tvalid),
        .o_bin      (w_out_bin),
        .o_word     (w_out_word)
    );

    assign m_axis_tdata = {w_out_word, w_out_bin};

endmodule

[tb/rolling_canonical_kmer_packer_top_test.sv]
// Self-checking testbench for the rolling canonical k-mer packer top level.
module rolling_canonical_kmer_packer_top_test;

    // Kind of one row in the directed stimulus table.
    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    // One directed row: an item (val = character) or a register write (val = data).
    // A pinned row carries a hand-typed result that replaces the predicted one.
    typedef struct packed {
        t_row_kind                       kind;
        rckp_pkg::t_cfg_idx              idx;
        logic [7:0]                      val;
        logic                            ns;
        logic                            pinned;
        logic [rckp_pkg::BIN_W-1:0]      pbin;
        logic [rckp_pkg::WORD_W-1:0]     pword;
    } t_step;

    // One expected (bin, word) result.
    typedef struct {
        logic [rckp_pkg::BIN_W-1:0]  bin;
        logic [rckp_pkg::WORD_W-1:0] word;
    } t_kmer_pair;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 110;

    localparam rckp_pkg::t_cfg_idx IDX_KLEN  = rckp_pkg::CFG_KMER_LEN;
    localparam rckp_pkg::t_cfg_idx IDX_CANON = rckp_pkg::CFG_CANON;

    // Two-bit code of a character, indexed by its bits 2:1.
    localparam logic [rckp_pkg::NUC_W-1:0] NUC_OF [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
    localparam logic [7:0] LETTERS [8] = '{8'h41, 8'h43, 8'h47, 8'h54,
                                           8'h61, 8'h63, 8'h67, 8'h74};

    // Directed part: a clamped length, forward and canonical output, every letter,
    // aliasing characters, the window-not-full startup and a palindromic tie.
    localparam int NSTEPS = 26;
    localparam t_step STEPS [NSTEPS] = '{
        '{ROW_CFG,  IDX_KLEN,  8'h00, 1'b0, 1'b0, 8'h00, 64'h0},  // zero acts as one
        '{ROW_CFG,  IDX_CANON, 8'h00, 1'b0, 1'b0, 8'h00, 64'h0},  // forward output
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b1, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b0, 1'b1, 8'h00, 64'h0},  // first full window
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h47, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h43, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h61, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'hFF, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h00, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_CFG,  IDX_CANON, 8'h3F, 1'b0, 1'b0, 8'h00, 64'h0},  // canonical, junk bits
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b1, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b1, 8'h00, 64'h0},  // all T folds to all A
        '{ROW_CFG,  IDX_KLEN,  8'h02, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b1, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h41, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b0, 8'h00, 64'h0},
        '{ROW_ITEM, IDX_KLEN,  8'h54, 1'b0, 1'b0, 8'h00, 64'h0}   // window equals its rc
    };

    // Register settings of the first random phases: extremes of both registers.
    localparam logic [rckp_pkg::KLEN_W-1:0] FIXED_KLEN [5] =
        '{6'd32, 6'd33, 6'd1, 6'd63, 6'd0};
    localparam logic FIXED_CANON [5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [rckp_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [rckp_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rckp_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rckp_pkg::M_TDATA_W-1:0]  m_axis_tdata;

    // Register mirror and window state of the predictor.
    logic [rckp_pkg::KLEN_W-1:0] cfg_klen  = rckp_pkg::KLEN_RESET;
    logic                        cfg_canon = rckp_pkg::CANON_RESET;
    logic [rckp_pkg::WORD_W-1:0] win_word  = '0;
    logic [rckp_pkg::BIN_W-1:0]  win_bin   = '0;
    logic [rckp_pkg::KLEN_W-1:0] seen_cnt  = '0;

    t_kmer_pair pending_pairs[$];
    int         errs        = 0;
    int         idle_cycles = 0;
    bit         calm        = 1'b0;  // high: neither side idles

    rolling_canonical_kmer_packer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] base_char
        .s_axis_tuser  (s_axis_tuser),   // [0] new_sequence
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [7:0] bin_prefix, [71:8] kmer_word
    );

    always #2 i_clk = ~i_clk;

    // Shift one character into the window; return 1 with the emitted pair once
    // the window holds k+4 nucleotides.
    function automatic bit pack_base(input logic [7:0] ch, input logic ns,
                                     output logic [rckp_pkg::BIN_W-1:0] ob,
                                     output logic [rckp_pkg::WORD_W-1:0] ow);
        int                          k;
        int                          n;
        logic [rckp_pkg::WORD_W-1:0] msk;
        logic [rckp_pkg::WORD_W-1:0] oldest;
        logic [71:0]                 fwd;
        logic [71:0]                 rev;
        k = int'(cfg_klen);
        if (k < 1) k = 1;
        if (k > rckp_pkg::MAX_KMER_LEN) k = rckp_pkg::MAX_KMER_LEN;
        msk = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
        ob  = '0;
        ow  = '0;
        if (ns) begin
            win_word = '0;
            win_bin  = '0;
            seen_cnt = '0;
        end
        // Move the oldest word nucleotide into the bin, then the new code into the word.
        oldest   = win_word >> (2 * k - 2);
        win_bin  = {win_bin[5:0], oldest[1:0]};
        win_word = ((win_word << 2) | rckp_pkg::WORD_W'(NUC_OF[ch[2:1]])) & msk;
        if (seen_cnt < rckp_pkg::FILL_MAX) seen_cnt = seen_cnt + 1'b1;
        if (int'(seen_cnt) < k + 4) return 1'b0;
        ob = win_bin;
        ow = win_word;
        if (cfg_canon) begin
            // Whole window as one number, oldest nucleotide on top; the reverse
            // complement takes the newest nucleotide first.
            n   = k + 4;
            fwd = (72'(win_bin) << (2 * k)) | 72'(win_word);
            rev = '0;
            for (int i = 0; i < n; i++)
                rev = {rev[69:0], fwd[2 * i +: 2] ^ rckp_pkg::NUC_COMP};
            if (rev < fwd) begin
                ob = 8'(rev >> (2 * k));
                ow = rev[63:0] & msk;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit idle_coin();
        return !calm && ($urandom_range(99) < 15);
    endfunction

    // Offer one item, hold it until taken, then queue its predicted result.
    task automatic send_base(input logic [7:0] ch, input logic ns, input logic pinned,
                             input logic [rckp_pkg::BIN_W-1:0] pbin,
                             input logic [rckp_pkg::WORD_W-1:0] pword);
        t_kmer_pair                  pair;
        logic [rckp_pkg::BIN_W-1:0]  pb;
        logic [rckp_pkg::WORD_W-1:0] pw;
        @(negedge i_clk);
        while (idle_coin()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= ns;
        do @(posedge i_clk); while (!s_axis_tready);
        if (pack_base(ch, ns, pb, pw)) begin
            pair.bin  = pinned ? pbin : pb;
            pair.word = pinned ? pword : pw;
            pending_pairs = {pending_pairs, pair};
        end
    endtask

    // Stop offering items, wait for every expected result, then let the pipe settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rckp_pkg::t_cfg_idx idx,
                             input logic [rckp_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            rckp_pkg::CFG_KMER_LEN: cfg_klen  = val;
            rckp_pkg::CFG_CANON:    cfg_canon = val[0];
            default:                ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result ready: stall at random except in calm stretches.
    always @(negedge i_clk)
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);

    // Compare each taken result with the oldest expected pair.
    always @(posedge i_clk) begin
        t_kmer_pair want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pairs.size() == 0) begin
                $error("unexpected result: bin_prefix %h kmer_word %h",
                       m_axis_tdata[7:0], m_axis_tdata[71:8]);
                errs++;
            end else begin
                want = pending_pairs.pop_front();
                if (m_axis_tdata[7:0] !== want.bin) begin
                    $error("bin_prefix: expected %h, got %h", want.bin, m_axis_tdata[7:0]);
                    errs++;
                end
                if (m_axis_tdata[71:8] !== want.word) begin
                    $error("kmer_word: expected %h, got %h", want.word, m_axis_tdata[71:8]);
                    errs++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0]                  ch;
        logic                        ns;
        logic [rckp_pkg::KLEN_W-1:0] klen;
        logic                        canon;

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        for (int r = 0; r < NSTEPS; r++) begin
            if (STEPS[r].kind == ROW_CFG) begin
                drain();
                write_reg(STEPS[r].idx, STEPS[r].val[rckp_pkg::CFG_DATA_W-1:0]);
            end else begin
                send_base(STEPS[r].val, STEPS[r].ns, STEPS[r].pinned,
                          STEPS[r].pbin, STEPS[r].pword);
            end
        end

        // Random phases: new settings each phase, window state carried across so
        // a length change lands in the middle of a sequence.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                klen  = FIXED_KLEN[p];
                canon = FIXED_CANON[p];
            end else begin
                klen  = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                 : 6'($urandom_range(1, 8));
                canon = 1'($urandom_range(1));
            end
            drain();
            write_reg(rckp_pkg::CFG_KMER_LEN, klen);
            write_reg(rckp_pkg::CFG_CANON, {5'($urandom_range(31)), canon});
            calm = (p == 2);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                // Mostly clean letters in both cases; some raw bytes as noise.
                if ($urandom_range(99) < 8)
                    ch = 8'($urandom_range(255));
                else
                    ch = LETTERS[$urandom_range(7)];
                ns = ($urandom_range(149) == 0);
                send_base(ch, ns, 1'b0, '0, '0);
            end
        end
        calm = 1'b0;

        // Let every result drain, then report.
        drain();
        if (errs == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rckp_pkg.sv
hw/rtl/rckp_cell.sv
hw/rtl/rckp_canon.sv
hw/rtl/rolling_canonical_kmer_packer_top.sv
tb/rolling_canonical_kmer_packer_top_test.sv
